@@ sv/sliced_ring_capture_defines.svh @@
// Assertion macros for the capture ring RTL.
`ifndef SLICED_RING_CAPTURE_DEFINES_SVH
`define SLICED_RING_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scr same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scr next-cycle check failed");

`else

`define SCR_ASSERT_IMP(label, ante, cons)
`define SCR_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ sv/scr_pkg.sv @@
// Shared constants and types for the sliced capture ring.
package scr_pkg;

   // Ring geometry
   localparam int SLICE_DEPTH  = 16;
   localparam int NUM_SLICES   = 4;
   localparam int SNAP_LEN     = 32;
   localparam int RING_LEN     = SLICE_DEPTH * NUM_SLICES;
   localparam int START_OFFSET = 2;

   // Derived widths
   localparam int RING_AW  = $clog2(RING_LEN);
   localparam int SLICE_W  = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
   localparam int CNT_W    = $clog2(SNAP_LEN + 1);
   localparam int SAMPLE_W = 24;

   // Transaction opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SNAP  = 1'b1;

   // Ring write port
   typedef struct packed {
      logic                en;
      logic [RING_AW-1:0]  addr;
      logic [SAMPLE_W-1:0] data;
   } scr_wr_type;

   // Ring read port
   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
   } scr_rd_type;

endpackage

@@ sv/scr_ring.sv @@
// Sample ring memory with per-entry valid bits and registered read data.
module scr_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  scr_pkg::scr_wr_type            wr,
   input  scr_pkg::scr_rd_type            rd,
   output logic [scr_pkg::SAMPLE_W-1:0]   rd_data
);

   logic [scr_pkg::SAMPLE_W-1:0] mem [scr_pkg::RING_LEN];
   logic [scr_pkg::RING_LEN-1:0] valid_ff;
   logic [scr_pkg::SAMPLE_W-1:0] rd_data_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Entry valid bits; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Registered read, holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= valid_ff[rd.addr] ? mem[rd.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sliced_ring_capture.sv @@
// Top level of the sliced capture ring: control, position tracking and result stage.
//
// Records a stream of Q1.23 samples into a 64-entry ring (4 slices of 16) and
// reads out snapshots. A write is stored as it is accepted, and the block stays
// ready for the next. A snapshot whose slice has not moved since the previous
// snapshot gives one result (fresh = 0, last = 1) from the stale state once the
// result stage is free. Otherwise it streams 32 samples, one ring memory read per
// cycle while the result stage is free, starting two slices ahead of the current
// one; the block is busy until the last read, and a stall on rsp_ready holds it.
// The single memory read port sets the one-sample-per-cycle stream rate. The ring
// reads as zeros after reset through per-entry valid bits, with no clearing pass.
`include "sliced_ring_capture_defines.svh"

module sliced_ring_capture (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [scr_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_fresh,
   output logic signed [scr_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_STALE  = 3'b010,
      ST_STREAM = 3'b100
   } scr_state_type;

   scr_state_type                  state_ff, state_in;
   logic [scr_pkg::RING_AW-1:0]    wpos_ff, wpos_in;
   logic [scr_pkg::SLICE_W-1:0]    rslice_ff, rslice_in;
   logic                           rvalid_ff, rvalid_in;
   logic [scr_pkg::RING_AW-1:0]    raddr_ff, raddr_in;
   logic [scr_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           fresh_ff, fresh_in;
   logic                           last_ff, last_in;

   scr_pkg::scr_wr_type            wr;
   scr_pkg::scr_rd_type            rd;
   logic [scr_pkg::SAMPLE_W-1:0]   rd_data;

   logic [scr_pkg::RING_AW-1:0]    wpos_div;
   logic [scr_pkg::SLICE_W-1:0]    cur_slice;
   logic [scr_pkg::SLICE_W:0]      slice_sum;
   logic [scr_pkg::SLICE_W-1:0]    start_slice;
   logic [scr_pkg::RING_AW-1:0]    start_idx;
   logic                           out_free;
   logic                           cnt_last;

   scr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // Current slice and snapshot start, two slices ahead with wrap
   assign wpos_div  = scr_pkg::RING_AW'(wpos_ff / scr_pkg::SLICE_DEPTH);
   assign cur_slice = wpos_div[scr_pkg::SLICE_W-1:0];
   assign slice_sum = {1'b0, cur_slice} + (scr_pkg::SLICE_W + 1)'(scr_pkg::START_OFFSET);
   always_comb begin
      if (slice_sum >= (scr_pkg::SLICE_W + 1)'(scr_pkg::NUM_SLICES)) begin
         start_slice = scr_pkg::SLICE_W'(slice_sum - (scr_pkg::SLICE_W + 1)'(scr_pkg::NUM_SLICES));
      end else begin
         start_slice = slice_sum[scr_pkg::SLICE_W-1:0];
      end
   end
   assign start_idx = scr_pkg::RING_AW'(start_slice * scr_pkg::SLICE_DEPTH);

   // Result stage can take a new transaction
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_last = (cnt_ff == scr_pkg::CNT_W'(scr_pkg::SNAP_LEN - 1));

   // Control sequencer; writes only in idle, reads only while streaming
   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      rslice_in    = rslice_ff;
      rvalid_in    = rvalid_ff;
      raddr_in     = raddr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fresh_in     = fresh_ff;
      last_in      = last_ff;
      wr           = '0;
      rd.en        = 1'b0;
      rd.addr      = raddr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == scr_pkg::OP_WRITE) begin
                  wr.en   = 1'b1;
                  wr.addr = wpos_ff;
                  wr.data = req_sample;
                  if (wpos_ff == scr_pkg::RING_AW'(scr_pkg::RING_LEN - 1)) begin
                     wpos_in = '0;
                  end else begin
                     wpos_in = wpos_ff + 1'b1;
                  end
               end else if (rvalid_ff && (rslice_ff == cur_slice)) begin
                  state_in = ST_STALE;
               end else begin
                  raddr_in  = start_idx;
                  cnt_in    = '0;
                  rslice_in = cur_slice;
                  rvalid_in = 1'b1;
                  state_in  = ST_STREAM;
               end
            end
         end
         ST_STALE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               fresh_in     = 1'b0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (out_free) begin
               rd.en        = 1'b1;
               rsp_valid_in = 1'b1;
               fresh_in     = 1'b1;
               last_in      = cnt_last;
               cnt_in       = cnt_ff + 1'b1;
               if (raddr_ff == scr_pkg::RING_AW'(scr_pkg::RING_LEN - 1)) begin
                  raddr_in = '0;
               end else begin
                  raddr_in = raddr_ff + 1'b1;
               end
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         rslice_ff    <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         rslice_ff    <= rslice_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      raddr_ff <= raddr_in;
      cnt_ff   <= cnt_in;
      fresh_ff <= fresh_in;
      last_ff  <= last_in;
   end

   // Ports; nothing is taken while reset is held
   assign req_ready      = !reset && (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fresh      = fresh_ff;
   assign rsp_last       = last_ff;
   assign rsp_sample_out = fresh_ff ? rd_data : '0;

   // Checks
   `SCR_ASSERT_IMP(a_stale_is_last, rsp_valid_ff && !fresh_ff, last_ff)
   `SCR_ASSERT_IMP(a_no_write_while_streaming, state_ff == ST_STREAM, !wr.en)
   `SCR_ASSERT_IMP(a_cnt_in_range, state_ff == ST_STREAM, cnt_ff <= scr_pkg::CNT_W'(scr_pkg::SNAP_LEN - 1))
   `SCR_ASSERT_NXT(a_snap_records_slice, req_valid && req_ready && (req_op == scr_pkg::OP_SNAP), rvalid_ff)

endmodule
